[rtl/core/btb_pkg.sv]
// Package for the two-bit branch target buffer: sizes, entry layout,
// counter constants and the controller state type. No dependencies.
package btb_pkg;

  localparam int unsigned PC_W         = 32;
  localparam int unsigned INDEX_BITS   = 10;
  localparam int unsigned COUNTER_BITS = 2;
  localparam int unsigned TAG_W        = PC_W - INDEX_BITS;
  localparam int unsigned DEPTH        = 1 << INDEX_BITS;

  typedef logic [INDEX_BITS-1:0]   index_t;
  typedef logic [TAG_W-1:0]        tag_t;
  typedef logic [PC_W-1:0]         addr_t;
  typedef logic [COUNTER_BITS-1:0] ctr_t;

  // Counter codes: saturated high, saturated low, weakly taken, weakly not taken
  localparam ctr_t CTR_MAX            = {COUNTER_BITS{1'b1}};
  localparam ctr_t CTR_ZERO           = '0;
  localparam ctr_t CTR_WEAK_TAKEN     = ctr_t'(1) << (COUNTER_BITS - 1);
  localparam ctr_t CTR_WEAK_NOT_TAKEN = CTR_WEAK_TAKEN - ctr_t'(1);

  // Step from a pc to the next sequential instruction
  localparam addr_t PC_STEP = addr_t'(4);

  // Transaction kinds
  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_UPDATE = 1'b1;

  // One table entry as stored in the memory
  typedef struct packed {
    logic  valid;
    tag_t  tag;
    addr_t target;
    ctr_t  counter;
  } entry_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ
  } state_e;

endpackage

[rtl/core/btb_if.sv]
// Valid/ready channel interfaces for the branch target buffer.
// Depends on btb_pkg for the address width.
interface btb_req_if import btb_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  kind;
  addr_t pc;
  logic  branch_taken;
  addr_t jump_target;

  modport source (output valid, kind, pc, branch_taken, jump_target, input ready);
  modport sink   (input valid, kind, pc, branch_taken, jump_target, output ready);
endinterface

interface btb_rsp_if import btb_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  predict_jump;
  addr_t predict_target;

  modport source (output valid, predict_jump, predict_target, input ready);
  modport sink   (input valid, predict_jump, predict_target, output ready);
endinterface

[rtl/core/btb_two_bit_branch_predictor_unit.sv]
// Direct-mapped branch target buffer with two-bit saturating counters.
// Depends on btb_pkg and the channel interfaces in btb_if.sv.
//
//   channel   direction   carries
//   req_i     in          kind, pc, branch_taken, jump_target
//   rsp_o     out         predict_jump, predict_target (lookups only)
//
// Every transaction first reads the entry from the single-port table
// memory, then computes and writes back or answers.
// After reset a clearing pass walks all DEPTH (1024) entries, one per
// cycle, before the first request is taken.
// A lookup waits in the read stage while the response register is full
// and not being drained; a request can be taken while a response waits.
module btb_two_bit_branch_predictor_unit import btb_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  btb_req_if.sink         req_i,
  btb_rsp_if.source       rsp_o
);

  state_e state_q, state_d;
  index_t clr_idx_q, clr_idx_d;

  // Captured request
  logic  kind_q;
  addr_t pc_q;
  logic  taken_q;
  addr_t target_q;

  // Table memory
  entry_t mem [DEPTH];
  entry_t rdata_q;
  logic   mem_we;
  logic   mem_re;
  index_t mem_waddr;
  entry_t mem_wdata;

  // Response register
  logic  out_valid_q, out_valid_d;
  logic  out_jump_q;
  addr_t out_target_q;
  logic  out_load;

  logic   req_accept;
  logic   hit;
  index_t slot;
  tag_t   tag;
  ctr_t   ctr_next;
  entry_t upd_entry;
  logic   pred_jump;
  addr_t  pred_target;

  assign slot       = pc_q[INDEX_BITS-1:0];
  assign tag        = pc_q[PC_W-1:INDEX_BITS];
  assign req_accept = req_i.valid && req_i.ready;

  // Match the read entry against the captured pc
  assign hit = rdata_q.valid && (rdata_q.tag == tag);

  // Saturating counter step on a hit, weak initial value on a miss
  always_comb begin
    if (hit) begin
      if (taken_q) begin
        ctr_next = (rdata_q.counter == CTR_MAX) ? CTR_MAX : rdata_q.counter + ctr_t'(1);
      end else begin
        ctr_next = (rdata_q.counter == CTR_ZERO) ? CTR_ZERO : rdata_q.counter - ctr_t'(1);
      end
    end else begin
      ctr_next = taken_q ? CTR_WEAK_TAKEN : CTR_WEAK_NOT_TAKEN;
    end
  end

  always_comb begin
    upd_entry.valid   = 1'b1;
    upd_entry.tag     = tag;
    upd_entry.target  = target_q;
    upd_entry.counter = ctr_next;
  end

  // Prediction from the read entry
  assign pred_jump   = hit && rdata_q.counter[COUNTER_BITS-1];
  assign pred_target = pred_jump ? rdata_q.target : pc_q + PC_STEP;

  // Next state
  always_comb begin
    state_d   = state_q;
    clr_idx_d = clr_idx_q;
    case (state_q)
      ST_CLEAR: begin
        clr_idx_d = clr_idx_q + index_t'(1);
        if (clr_idx_q == index_t'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_accept) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (kind_q == KIND_UPDATE || !out_valid_q || rsp_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // Outputs of the controller
  always_comb begin
    req_i.ready = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = slot;
    mem_wdata   = upd_entry;
    out_load    = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx_q;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        req_i.ready = 1'b1;
        mem_re      = req_i.valid;
      end
      ST_READ: begin
        if (kind_q == KIND_UPDATE) begin
          mem_we = 1'b1;
        end else begin
          out_load = !out_valid_q || rsp_o.ready;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the response until taken, replace it on a new lookup
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Capture the request transaction
  always_ff @(posedge clk_i) begin
    if (req_accept) begin
      kind_q   <= req_i.kind;
      pc_q     <= req_i.pc;
      taken_q  <= req_i.branch_taken;
      target_q <= req_i.jump_target;
    end
  end

  // Load the response payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_jump_q   <= pred_jump;
      out_target_q <= pred_target;
    end
  end

  // Table memory: one write or one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[req_i.pc[INDEX_BITS-1:0]];
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.predict_jump   = out_jump_q;
  assign rsp_o.predict_target = out_target_q;

`ifndef NO_ASSERTIONS
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("table read and write in the same cycle");

  a_accept_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_accept |=> state_q == ST_READ)
    else $error("accepted transaction did not enter the read stage");

  a_clear_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR && clr_idx_q == index_t'(DEPTH - 1)) |=> state_q == ST_IDLE)
    else $error("clearing pass did not finish after the last entry");

  a_load_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (state_q == ST_READ && kind_q == KIND_LOOKUP))
    else $error("response loaded outside a lookup");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !rsp_o.ready) |-> !out_load)
    else $error("pending response overwritten");
`endif

endmodule
